// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SLPM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slpm assertion failed");

// Checked on every rising edge, reset included.
`define SLPM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("slpm assertion failed");

`endif

// ===== hw/rtl/slpm_pkg.sv =====
// Shared types and constants of the shaped LFO pitch modulator.
// Used by slpm_div and shaped_lfo_pitch_modulator; depends on nothing.
package slpm_pkg;

    localparam int PHASE_BITS_DEF  = 24;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int DIV_W  = 40;
    localparam int STEP_W = 6;

    localparam logic [24:0] ONE24       = 25'h100_0000;
    localparam logic [24:0] MIN_DIV_Q24 = 25'd16777;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [23:0] PITCH_MIN = -24'sd2359296;
    localparam logic signed [23:0] PITCH_MAX = 24'sd1572864;

    typedef enum logic [2:0] {
        CFG_RATE_HZ     = 3'd0,
        CFG_SYMMETRY    = 3'd1,
        CFG_WAVE_SHAPE  = 3'd2,
        CFG_AMPLITUDE   = 3'd3,
        CFG_QUANTIZE    = 3'd4,
        CFG_SAMPLE_RATE = 3'd5,
        CFG_HOP_COUNT   = 3'd6,
        CFG_FRAME_SIZE  = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INC_MUL,
        ST_INC_DEN,
        ST_INC_DIV,
        ST_INC_WAIT,
        ST_SYM,
        ST_R_WAIT,
        ST_SHAPE,
        ST_Y_WAIT,
        ST_SIN_MUL,
        ST_SIN_READ,
        ST_SIN_USE,
        ST_COS_MUL1,
        ST_COS_MUL2,
        ST_COS_SUM,
        ST_AMP_MUL,
        ST_LFO,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_rsp_t;

endpackage

// ===== hw/rtl/slpm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on slpm_pkg for the request and response structs.
module slpm_div #(
    parameter int QW = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  slpm_pkg::div_req_t req,
    output slpm_pkg::div_rsp_t rsp,
    output logic [QW-1:0]     quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              sat_reg;
    logic [slpm_pkg::STEP_W-1:0]       cnt_reg;
    logic [slpm_pkg::DIV_W-1:0]        rem_reg;
    logic [slpm_pkg::DIV_W-1:0]        den_reg;
    logic [QW-1:0]                     quot_reg;
    logic [slpm_pkg::DIV_W-1:0]        rem_shift;
    logic                              q_bit;
    logic [slpm_pkg::DIV_W-1:0]        rem_next;

    always_comb
    begin
        rem_shift = {rem_reg[slpm_pkg::DIV_W-2:0], 1'b0};
        q_bit     = (rem_shift >= den_reg);
        rem_next  = q_bit ? (rem_shift - den_reg) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.num >= req.den)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= req.steps;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == slpm_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sat_reg  <= (req.num >= req.den);
            rem_reg  <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QW-2:0], q_bit};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign quot     = quot_reg;

endmodule

// ===== hw/rtl/shaped_lfo_pitch_modulator.sv =====
// Shaped LFO pitch modulator: sequencer, shared multiplier and sine ROM.
// Depends on slpm_pkg and instantiates slpm_div.
//
// Usage: each input item on pitch_offset (in_valid/in_stall) is one frame
// tick. The block advances its phase, forms the shaped and scaled wave and
// returns one result item (lfo_value, shifted_pitch) on out_valid/out_stall.
// in_stall is high while an item is being worked on.
// Once an item is accepted, the input is free again in the same cycle in
// which its result is loaded into the output register.
// Each item takes up to three passes through the shared divider, which
// yields one quotient bit per cycle (PHASE_BITS steps for the phase
// increment, 24 for the ramp, 24 for the squeezed sine), plus one shared
// multiplier used in sequence and a registered sine ROM read.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver still stalls when the following result is
// ready, the sequencer holds that result until the register frees up.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not enforce it.
// Reset clears the phase, loads the register defaults and drops out_valid.
module shaped_lfo_pitch_modulator #(
    parameter int PHASE_BITS         = slpm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_ENTRIES = slpm_pkg::SINE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [22:0] pitch_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] lfo_value,
    output logic signed [22:0] shifted_pitch,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [20:0]        cfg_data
);

    localparam int QW = (PHASE_BITS > 24) ? PHASE_BITS : 24;
    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);

    typedef logic [16:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

    function automatic sine_rom_t build_sine();
        sine_rom_t   tab;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++)
        begin
            x    = 64'(i) * slpm_pkg::HALF_PI_Q30 / 64'(SINE_TABLE_ENTRIES);
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 6; k++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > 65536)
            begin
                sum = 65536;
            end
            tab[i] = 17'(sum);
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    slpm_pkg::state_t state_reg, state_next;

    logic [20:0]        rate_reg;
    logic signed [15:0] sym_reg;
    logic signed [15:0] shape_reg;
    logic [15:0]        amp_reg;
    logic               quant_reg;
    logic [17:0]        fs_reg;
    logic [4:0]         hop_reg;
    logic [13:0]        frame_reg;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic signed [22:0]    offset_reg, offset_next;
    logic signed [45:0]    prod_reg;
    logic [slpm_pkg::DIV_W-1:0] num_reg, num_next;
    logic [24:0]           r_reg, r_next;
    logic                  br_reg, br_next;
    logic [24:0]           u_reg, u_next;
    logic                  neg_reg, neg_next;
    logic [16:0]           sin_reg;
    logic signed [25:0]    c_reg, c_next;
    logic signed [45:0]    acc_reg, acc_next;
    logic signed [25:0]    val_reg, val_next;
    logic signed [15:0]    lfo_reg, lfo_next;
    logic signed [15:0]    lfo_out_reg, lfo_out_next;
    logic signed [22:0]    pitch_out_reg, pitch_out_next;
    logic                  out_valid_reg, out_valid_next;

    logic signed [26:0]    mul_a;
    logic signed [18:0]    mul_b;
    logic [23:0]           x_aligned;
    logic [23:0]           t_val;
    logic [24:0]           one_minus_t;
    logic [25:0]           h_val;
    logic [15:0]           tk;
    logic [24:0]           d_val;
    logic signed [25:0]    ramp_num;
    logic [24:0]           ramp_mag;
    logic [46:0]           idx_sum;
    logic [IW-1:0]         rom_idx;
    logic signed [17:0]    s_val;
    logic signed [18:0]    c_diff;
    logic signed [18:0]    w_comp;
    logic signed [46:0]    cos_sum;
    logic signed [26:0]    val_w;
    logic signed [45:0]    lfo_sh;
    logic signed [19:0]    t12;
    logic [19:0]           t12_mag;
    logic signed [23:0]    term_q;
    logic signed [23:0]    term;
    logic signed [23:0]    pitch_sum;
    logic                  load_out;

    slpm_pkg::div_req_t div_req;
    slpm_pkg::div_rsp_t div_rsp;
    logic [QW-1:0]      div_quot;

    slpm_div #(
        .QW(QW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp),
        .quot (div_quot)
    );

    generate
        if (PHASE_BITS >= 24)
        begin : g_phase_wide
            assign x_aligned = phase_reg[PHASE_BITS-1 -: 24];
        end
        else
        begin : g_phase_narrow
            assign x_aligned = {phase_reg, {(24 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    always_comb
    begin
        t_val       = {sym_reg[15] ^ 1'b1, sym_reg[14:0], 8'h00};
        one_minus_t = slpm_pkg::ONE24 - {1'b0, t_val};
        h_val       = {r_reg, 1'b0};
        tk          = {~shape_reg[15], shape_reg[14:0]};
        d_val       = (tk <= 16'd32) ? slpm_pkg::MIN_DIV_Q24 : {tk[15:0], 9'd0};
        ramp_num    = $signed({r_reg, 1'b0}) - $signed({1'b0, slpm_pkg::ONE24});
        ramp_mag    = ramp_num[25] ? 25'(-ramp_num) : 25'(ramp_num);
        idx_sum     = 47'(prod_reg) + 47'h80_0000;
        if (idx_sum[46:24] > 23'(SINE_TABLE_ENTRIES))
        begin
            rom_idx = IW'(SINE_TABLE_ENTRIES);
        end
        else
        begin
            rom_idx = idx_sum[24 +: IW];
        end
        s_val   = neg_reg ? -$signed({1'b0, sin_reg}) : $signed({1'b0, sin_reg});
        c_diff  = 19'sd65536 - 19'(s_val);
        w_comp  = 19'sd32768 - 19'(shape_reg);
        cos_sum = 47'(acc_reg) + 47'(prod_reg);
        val_w   = $signed({cos_sum[40:15], 1'b0}) - 27'sd16777216;
        lfo_sh  = shape_reg[15] ? (prod_reg >>> 16) : (prod_reg >>> 24);
        t12     = (20'(lfo_reg) <<< 3) + (20'(lfo_reg) <<< 2);
        t12_mag = t12[19] ? 20'(-t12) : 20'(t12);
        term_q  = $signed({3'd0, t12_mag[19:15], 16'd0});
        if (quant_reg)
        begin
            term = t12[19] ? -term_q : term_q;
        end
        else
        begin
            term = 24'(lfo_reg) <<< 2;
        end
        pitch_sum = 24'(offset_reg) + term;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        num_next       = num_reg;
        r_next         = r_reg;
        br_next        = br_reg;
        u_next         = u_reg;
        neg_next       = neg_reg;
        c_next         = c_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        lfo_next       = lfo_reg;
        lfo_out_next   = lfo_out_reg;
        pitch_out_next = pitch_out_reg;
        load_out       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;

        case (state_reg)
            slpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    offset_next = pitch_offset;
                    state_next  = slpm_pkg::ST_INC_MUL;
                end
            end
            slpm_pkg::ST_INC_MUL:
            begin
                mul_a      = 27'(rate_reg);
                mul_b      = 19'(frame_reg);
                state_next = slpm_pkg::ST_INC_DEN;
            end
            slpm_pkg::ST_INC_DEN:
            begin
                mul_a      = 27'(fs_reg);
                mul_b      = 19'(hop_reg);
                num_next   = prod_reg[slpm_pkg::DIV_W-1:0];
                state_next = slpm_pkg::ST_INC_DIV;
            end
            slpm_pkg::ST_INC_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = num_reg;
                div_req.den   = {prod_reg[23:0], 16'd0};
                div_req.steps = slpm_pkg::STEP_W'(PHASE_BITS);
                state_next    = slpm_pkg::ST_INC_WAIT;
            end
            slpm_pkg::ST_INC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!div_rsp.sat)
                    begin
                        phase_next = phase_reg + div_quot[PHASE_BITS-1:0];
                    end
                    state_next = slpm_pkg::ST_SYM;
                end
            end
            slpm_pkg::ST_SYM:
            begin
                if (sym_reg == -16'sd32768)
                begin
                    r_next     = slpm_pkg::ONE24 - {1'b0, x_aligned};
                    state_next = slpm_pkg::ST_SHAPE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.steps = slpm_pkg::STEP_W'(24);
                    if (x_aligned <= t_val)
                    begin
                        div_req.num = slpm_pkg::DIV_W'(x_aligned);
                        div_req.den = slpm_pkg::DIV_W'(t_val);
                        br_next     = 1'b0;
                    end
                    else
                    begin
                        div_req.num = slpm_pkg::DIV_W'(x_aligned - t_val);
                        div_req.den = slpm_pkg::DIV_W'(one_minus_t);
                        br_next     = 1'b1;
                    end
                    state_next = slpm_pkg::ST_R_WAIT;
                end
            end
            slpm_pkg::ST_R_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.sat)
                    begin
                        r_next = br_reg ? 25'd0 : slpm_pkg::ONE24;
                    end
                    else
                    begin
                        r_next = br_reg ? (slpm_pkg::ONE24 - {1'b0, div_quot[23:0]})
                                        : {1'b0, div_quot[23:0]};
                    end
                    state_next = slpm_pkg::ST_SHAPE;
                end
            end
            slpm_pkg::ST_SHAPE:
            begin
                if (!shape_reg[15])
                begin
                    if (h_val <= 26'(slpm_pkg::ONE24))
                    begin
                        u_next   = 25'(26'(slpm_pkg::ONE24) - h_val);
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        u_next   = 25'(h_val - 26'(slpm_pkg::ONE24));
                        neg_next = 1'b1;
                    end
                    state_next = slpm_pkg::ST_SIN_MUL;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = slpm_pkg::DIV_W'(ramp_mag);
                    div_req.den   = slpm_pkg::DIV_W'(d_val);
                    div_req.steps = slpm_pkg::STEP_W'(24);
                    neg_next      = ramp_num[25];
                    state_next    = slpm_pkg::ST_Y_WAIT;
                end
            end
            slpm_pkg::ST_Y_WAIT:
            begin
                if (div_rsp.done)
                begin
                    u_next     = div_rsp.sat ? slpm_pkg::ONE24 : {1'b0, div_quot[23:0]};
                    state_next = slpm_pkg::ST_SIN_MUL;
                end
            end
            slpm_pkg::ST_SIN_MUL:
            begin
                mul_a      = 27'(u_reg);
                mul_b      = 19'(SINE_TABLE_ENTRIES);
                state_next = slpm_pkg::ST_SIN_READ;
            end
            slpm_pkg::ST_SIN_READ:
            begin
                state_next = slpm_pkg::ST_SIN_USE;
            end
            slpm_pkg::ST_SIN_USE:
            begin
                if (!shape_reg[15])
                begin
                    c_next     = $signed({c_diff[18:0], 7'd0});
                    state_next = slpm_pkg::ST_COS_MUL1;
                end
                else
                begin
                    val_next   = 26'(s_val);
                    state_next = slpm_pkg::ST_AMP_MUL;
                end
            end
            slpm_pkg::ST_COS_MUL1:
            begin
                mul_a      = 27'(c_reg);
                mul_b      = 19'(shape_reg);
                state_next = slpm_pkg::ST_COS_MUL2;
            end
            slpm_pkg::ST_COS_MUL2:
            begin
                acc_next   = prod_reg;
                mul_a      = $signed({2'b00, r_reg});
                mul_b      = w_comp;
                state_next = slpm_pkg::ST_COS_SUM;
            end
            slpm_pkg::ST_COS_SUM:
            begin
                val_next   = val_w[25:0];
                state_next = slpm_pkg::ST_AMP_MUL;
            end
            slpm_pkg::ST_AMP_MUL:
            begin
                mul_a      = 27'(val_reg);
                mul_b      = 19'(amp_reg);
                state_next = slpm_pkg::ST_LFO;
            end
            slpm_pkg::ST_LFO:
            begin
                if (lfo_sh > 46'sd32767)
                begin
                    lfo_next = 16'sd32767;
                end
                else if (lfo_sh < -46'sd32768)
                begin
                    lfo_next = -16'sd32768;
                end
                else
                begin
                    lfo_next = lfo_sh[15:0];
                end
                state_next = slpm_pkg::ST_EMIT;
            end
            slpm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out     = 1'b1;
                    lfo_out_next = lfo_reg;
                    if (pitch_sum < slpm_pkg::PITCH_MIN)
                    begin
                        pitch_out_next = slpm_pkg::PITCH_MIN[22:0];
                    end
                    else if (pitch_sum > slpm_pkg::PITCH_MAX)
                    begin
                        pitch_out_next = slpm_pkg::PITCH_MAX[22:0];
                    end
                    else
                    begin
                        pitch_out_next = pitch_sum[22:0];
                    end
                    state_next = slpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slpm_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load_out | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slpm_pkg::ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= 21'd327680;
            sym_reg       <= '0;
            shape_reg     <= '0;
            amp_reg       <= '0;
            quant_reg     <= 1'b0;
            fs_reg        <= 18'd48000;
            hop_reg       <= 5'd4;
            frame_reg     <= 14'd2048;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (slpm_pkg::cfg_idx_t'(cfg_addr))
                    slpm_pkg::CFG_RATE_HZ:     rate_reg  <= cfg_data;
                    slpm_pkg::CFG_SYMMETRY:    sym_reg   <= cfg_data[15:0];
                    slpm_pkg::CFG_WAVE_SHAPE:  shape_reg <= cfg_data[15:0];
                    slpm_pkg::CFG_AMPLITUDE:   amp_reg   <= cfg_data[15:0];
                    slpm_pkg::CFG_QUANTIZE:    quant_reg <= cfg_data[0];
                    slpm_pkg::CFG_SAMPLE_RATE: fs_reg    <= cfg_data[17:0];
                    slpm_pkg::CFG_HOP_COUNT:   hop_reg   <= cfg_data[4:0];
                    slpm_pkg::CFG_FRAME_SIZE:  frame_reg <= cfg_data[13:0];
                    default:                   rate_reg  <= rate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= mul_a * mul_b;
        sin_reg       <= SINE_ROM[rom_idx];
        offset_reg    <= offset_next;
        num_reg       <= num_next;
        r_reg         <= r_next;
        br_reg        <= br_next;
        u_reg         <= u_next;
        neg_reg       <= neg_next;
        c_reg         <= c_next;
        acc_reg       <= acc_next;
        val_reg       <= val_next;
        lfo_reg       <= lfo_next;
        lfo_out_reg   <= lfo_out_next;
        pitch_out_reg <= pitch_out_next;
    end

    assign in_stall      = (state_reg != slpm_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign lfo_value     = lfo_out_reg;
    assign shifted_pitch = pitch_out_reg;

endmodule

// ===== hw/rtl/slpm_checker.sv =====
// Port-level checker for shaped_lfo_pitch_modulator, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module slpm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] lfo_value,
    input logic signed [22:0] shifted_pitch
);

    `SLPM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
    `SLPM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(lfo_value) && $stable(shifted_pitch))
    `SLPM_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
    `SLPM_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall))
    `SLPM_ASSERT_ALWAYS(a_pitch_range, !out_valid || ((shifted_pitch >= -23'sd2359296) && (shifted_pitch <= 23'sd1572864)))

endmodule

bind shaped_lfo_pitch_modulator slpm_checker u_slpm_checker (.*);
